// File: hw/rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse pipeline.
// No dependencies.
package mi3_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int THR_WIDTH      = 31;
   localparam int NUM_ELEM       = 9;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   // cofactor k = e[a]*e[b] - e[c]*e[d], elements row by row
   localparam logic [3:0] ADJ_IDX [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // det = e0*adj0 + e1*adj3 + e2*adj6
   localparam logic [3:0] DET_ADJ [3] = '{4'd0, 4'd3, 4'd6};

   typedef struct packed {
      logic valid;
      logic singular;
   } mi3_stat_type;

endpackage

// File: hw/rtl/mi3_adjugate.sv
// Adjugate stages: cofactor products, then differences.
// Depends on mi3_pkg.
module mi3_adjugate import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic signed [ELEM_WIDTH-1:0] elem [NUM_ELEM],
   output logic signed [2*ELEM_WIDTH:0] adj [NUM_ELEM],
   output logic signed [ELEM_WIDTH-1:0] row0 [3]
);
   localparam int PW = 2 * ELEM_WIDTH;

   logic signed [PW-1:0]         p_in  [NUM_ELEM], q_in [NUM_ELEM];
   logic signed [PW-1:0]         p_ff  [NUM_ELEM], q_ff [NUM_ELEM];
   logic signed [PW:0]           adj_in [NUM_ELEM], adj_ff [NUM_ELEM];
   logic signed [ELEM_WIDTH-1:0] r0a_ff [3], r0b_ff [3];

   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         p_in[k]   = elem[ADJ_IDX[k][0]] * elem[ADJ_IDX[k][1]];
         q_in[k]   = elem[ADJ_IDX[k][2]] * elem[ADJ_IDX[k][3]];
         adj_in[k] = (PW+1)'(p_ff[k]) - (PW+1)'(q_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         p_ff[k]   <= p_in[k];
         q_ff[k]   <= q_in[k];
         adj_ff[k] <= adj_in[k];
      end
      for (int i = 0; i < 3; i++) begin
         r0a_ff[i] <= elem[i];
         r0b_ff[i] <= r0a_ff[i];
      end
   end

   assign adj  = adj_ff;
   assign row0 = r0b_ff;

endmodule

// File: hw/rtl/mi3_det.sv
// Determinant stages: split partial products, sum, magnitudes and singular test.
// Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid,
   input  logic [THR_WIDTH-1:0]          threshold,
   input  logic signed [2*ELEM_WIDTH:0]  adj [NUM_ELEM],
   input  logic signed [ELEM_WIDTH-1:0]  row0 [3],
   output logic [2*ELEM_WIDTH-1:0]       adj_mag [NUM_ELEM],
   output logic                          adj_neg [NUM_ELEM],
   output logic [3*ELEM_WIDTH:0]         det_mag,
   output logic                          det_neg,
   output mi3_stat_type                  stat
);
   localparam int W  = ELEM_WIDTH;
   localparam int AW = 2*W + 1;
   localparam int AM = 2*W;
   localparam int DW = 3*W + 2;
   localparam int DM = 3*W + 1;
   localparam int TW = THR_WIDTH + 2*FRAC_BITS;
   localparam int CW = (DM > TW) ? DM : TW;

   logic signed [2*W:0]   lo_in [3], hi_in [3], lo_ff [3], hi_ff [3];
   logic signed [AW-1:0]  adj3_ff [NUM_ELEM], adj4_ff [NUM_ELEM];
   logic signed [DW-1:0]  det_in, det_ff, det_abs;
   logic signed [AW-1:0]  adj_abs [NUM_ELEM];
   logic [AM-1:0]         amag_in [NUM_ELEM], amag_ff [NUM_ELEM];
   logic                  aneg_ff [NUM_ELEM];
   logic [DM-1:0]         dmag_in, dmag_ff;
   logic                  dneg_ff;
   logic                  v3_ff, v4_ff;
   mi3_stat_type          stat_in, stat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = row0[i] * $signed({1'b0, adj[DET_ADJ[i]][W-1:0]});
         hi_in[i] = row0[i] * $signed(adj[DET_ADJ[i]][AW-1:W]);
      end
      det_in = '0;
      for (int i = 0; i < 3; i++) begin
         det_in = det_in + (DW'(hi_ff[i]) <<< W) + DW'(lo_ff[i]);
      end
      det_abs = det_ff[DW-1] ? -det_ff : det_ff;
      dmag_in = det_abs[DM-1:0];
      for (int k = 0; k < NUM_ELEM; k++) begin
         adj_abs[k] = adj4_ff[k][AW-1] ? -adj4_ff[k] : adj4_ff[k];
         amag_in[k] = adj_abs[k][AM-1:0];
      end
      stat_in.valid    = v4_ff;
      stat_in.singular = CW'(dmag_in) <= (CW'(threshold) << (2*FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      adj3_ff <= adj;
      adj4_ff <= adj3_ff;
      det_ff  <= det_in;
      dmag_ff <= dmag_in;
      dneg_ff <= det_ff[DW-1];
      for (int k = 0; k < NUM_ELEM; k++) begin
         amag_ff[k] <= amag_in[k];
         aneg_ff[k] <= adj4_ff[k][AW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         stat_ff <= '0;
      end else begin
         v3_ff   <= valid;
         v4_ff   <= v3_ff;
         stat_ff <= stat_in;
      end
   end

   assign adj_mag = amag_ff;
   assign adj_neg = aneg_ff;
   assign det_mag = dmag_ff;
   assign det_neg = dneg_ff;
   assign stat    = stat_ff;

endmodule

// File: hw/rtl/mi3_div.sv
// One divider lane: overflow check, one restoring quotient bit per stage,
// then round half away from zero and saturate. Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic [2*ELEM_WIDTH-1:0]       num_mag,
   input  logic                          num_neg,
   input  logic [3*ELEM_WIDTH:0]         den_mag,
   input  logic                          den_neg,
   output logic signed [ELEM_WIDTH-1:0]  quo
);
   localparam int W  = ELEM_WIDTH;
   localparam int AM = 2*W;
   localparam int DM = 3*W + 1;
   localparam int NW = AM + 2*FRAC_BITS;
   localparam int XW = ((NW > DM + W) ? NW : DM + W) + 1;

   logic [XW-1:0] rem_in [W+1], rem_ff [W+1];
   logic [W-1:0]  q_in   [W+1], q_ff   [W+1];
   logic [DM-1:0] d_ff   [W+1];
   logic          neg_ff [W+1], big_ff [W+1];
   logic          big_in;
   logic [XW-1:0] sh [W+1];
   logic          ge [W+1];
   logic          rnd, neg_eff;
   logic [W:0]    qr, lim, sat;
   logic [W-1:0]  quo_in, quo_ff;

   always_comb begin
      // stage 0: a quotient wider than W bits saturates
      rem_in[0] = XW'(num_mag) << (2*FRAC_BITS);
      sh[0]     = XW'(den_mag) << W;
      ge[0]     = rem_in[0] >= sh[0];
      big_in    = ge[0];
      q_in[0]   = '0;
      for (int k = 1; k <= W; k++) begin
         sh[k]     = XW'(d_ff[k-1]) << (W - k);
         ge[k]     = rem_ff[k-1] >= sh[k];
         rem_in[k] = ge[k] ? rem_ff[k-1] - sh[k] : rem_ff[k-1];
         q_in[k]   = {q_ff[k-1][W-2:0], ge[k]};
      end
      rnd     = ((XW+1)'(rem_ff[W]) << 1) >= (XW+1)'(d_ff[W]);
      qr      = (W+1)'(q_ff[W]) + (W+1)'(rnd);
      lim     = ((W+1)'(1) << (W-1)) - (W+1)'(!neg_ff[W]);
      sat     = (big_ff[W] || qr > lim) ? lim : qr;
      neg_eff = neg_ff[W] && (sat != '0);
      quo_in  = neg_eff ? -sat[W-1:0] : sat[W-1:0];
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      q_ff[0]   <= q_in[0];
      d_ff[0]   <= den_mag;
      neg_ff[0] <= num_neg ^ den_neg;
      big_ff[0] <= big_in;
      for (int k = 1; k <= W; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
         d_ff[k]   <= d_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         big_ff[k] <= big_ff[k-1];
      end
      quo_ff <= quo_in;
   end

   assign quo = $signed(quo_ff);

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse pipeline.
// Depends on mi3_pkg, mi3_adjugate, mi3_det and mi3_div.

// One matrix word is taken in every clock at which start is high; busy is
// never raised, so words may follow back to back without a gap. Each word
// gives exactly one result word on the rsp_ ports, marked by rsp_valid for
// a single cycle, after passing two adjugate stages, three determinant
// stages, then a divider lane of ELEM_WIDTH + 2 stages (overflow check, one
// quotient bit per stage, round and saturate). The receiver cannot stall and
// must take every word.
// singular_threshold sits at byte address 0 of the csr port and should only
// be changed while no word is in flight.
module matrix_inverse_3x3 import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ELEM_WIDTH-1:0]  req_a11, req_a12, req_a13,
   input  logic signed [ELEM_WIDTH-1:0]  req_a21, req_a22, req_a23,
   input  logic signed [ELEM_WIDTH-1:0]  req_a31, req_a32, req_a33,
   // result words
   output logic                          rsp_valid,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r11, rsp_r12, rsp_r13,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r21, rsp_r22, rsp_r23,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r31, rsp_r32, rsp_r33,
   output logic                          rsp_singular,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);
   localparam int DIV_LAT = ELEM_WIDTH + 2;

   logic signed [ELEM_WIDTH-1:0] elem [NUM_ELEM];
   logic signed [2*ELEM_WIDTH:0] adj [NUM_ELEM];
   logic signed [ELEM_WIDTH-1:0] row0 [3];
   logic [2*ELEM_WIDTH-1:0]      adj_mag [NUM_ELEM];
   logic                         adj_neg [NUM_ELEM];
   logic [3*ELEM_WIDTH:0]        det_mag;
   logic                         det_neg;
   mi3_stat_type                 det_stat;
   mi3_stat_type                 stat_ff [DIV_LAT];
   logic signed [ELEM_WIDTH-1:0] quo [NUM_ELEM];
   logic signed [ELEM_WIDTH-1:0] res [NUM_ELEM];
   logic                         accept, v1_ff, v2_ff;
   logic [THR_WIDTH-1:0]         thr_ff, thr_in;
   logic                         csr_wr;

   // no backpressure anywhere
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---- register port: single writable register, zero-wait
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thr_in     = (csr_wr && csr_paddr[2] == CSR_IDX_THRESHOLD)
                       ? csr_pwdata[THR_WIDTH-1:0] : thr_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_THRESHOLD)
                       ? CSR_DATA_W'(thr_ff) : '0;

   // ---- element order is row by row
   assign elem[0] = req_a11;  assign elem[1] = req_a12;  assign elem[2] = req_a13;
   assign elem[3] = req_a21;  assign elem[4] = req_a22;  assign elem[5] = req_a23;
   assign elem[6] = req_a31;  assign elem[7] = req_a32;  assign elem[8] = req_a33;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         for (int s = 0; s < DIV_LAT; s++) stat_ff[s] <= '0;
      end else begin
         thr_ff     <= thr_in;
         v1_ff      <= accept;
         v2_ff      <= v1_ff;
         // status rides alongside the divider lanes
         stat_ff[0] <= det_stat;
         for (int s = 1; s < DIV_LAT; s++) stat_ff[s] <= stat_ff[s-1];
      end
   end

   mi3_adjugate #(.ELEM_WIDTH(ELEM_WIDTH)) u_adj (
      .clock (clock),
      .elem  (elem),
      .adj   (adj),
      .row0  (row0)
   );

   mi3_det #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_det (
      .clock     (clock),
      .reset     (reset),
      .valid     (v2_ff),
      .threshold (thr_ff),
      .adj       (adj),
      .row0      (row0),
      .adj_mag   (adj_mag),
      .adj_neg   (adj_neg),
      .det_mag   (det_mag),
      .det_neg   (det_neg),
      .stat      (det_stat)
   );

   // nine lanes share the determinant, one per inverse element
   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
      mi3_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .num_mag (adj_mag[k]),
         .num_neg (adj_neg[k]),
         .den_mag (det_mag),
         .den_neg (det_neg),
         .quo     (quo[k])
      );
   end

   // singular: identity replaces the quotients
   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         if (stat_ff[DIV_LAT-1].singular) begin
            res[k] = (k == 0 || k == 4 || k == 8)
                     ? (ELEM_WIDTH'(1) << FRAC_BITS) : '0;
         end else begin
            res[k] = quo[k];
         end
      end
   end

   assign rsp_valid    = stat_ff[DIV_LAT-1].valid;
   assign rsp_singular = stat_ff[DIV_LAT-1].singular;
   assign rsp_r11 = res[0];  assign rsp_r12 = res[1];  assign rsp_r13 = res[2];
   assign rsp_r21 = res[3];  assign rsp_r22 = res[4];  assign rsp_r23 = res[5];
   assign rsp_r31 = res[6];  assign rsp_r32 = res[7];  assign rsp_r33 = res[8];

endmodule
